// File: src/rbs_pkg.sv
// Shared constants, types and tables for the rainbow breathing sequencer.
package rbs_pkg;

   localparam int PROGRESS_BITS = 10;
   localparam int PROG_W        = PROGRESS_BITS + 1;
   localparam int STEP_W        = 10;
   localparam int DELAY_W       = 16;
   localparam int DUTY_W        = 10;
   localparam int TIME_W        = 32;
   localparam int ANGLE_W       = 17;
   localparam int Q15_W         = 16;
   localparam int MAG_W         = 17;
   localparam int HUE_W         = 4;

   localparam int MUL_A_W   = 31;
   localparam int MUL_B_W   = 16;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   localparam int DIV_N     = STEP_W + PROGRESS_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_N);

   localparam int COEF_N     = 5;
   localparam int COEF_IDX_W = $clog2(COEF_N);

   localparam logic [ANGLE_W-1:0] HALF_TURN    = ANGLE_W'(65536);
   localparam logic [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(32768);
   localparam logic [Q15_W-1:0]   Q15_ONE      = Q15_W'(32768);
   localparam logic [DUTY_W-1:0]  DUTY_LIMIT   = DUTY_W'(999);
   localparam logic [HUE_W-1:0]   PHASE_LAST   = HUE_W'(11);

   // floor(n / 10) = (n * 52429) >> 19 for n below 2^16
   localparam logic [MUL_B_W-1:0] TENTH_RECIP = MUL_B_W'(52429);
   localparam int                 TENTH_SHIFT = 19;
   localparam int                 TENTH_W     = 12;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_STEPS     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPDATE_DELAY   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEAK_INTENSITY = 2'd2;

   localparam logic [STEP_W-1:0]  FADE_STEPS_RESET     = STEP_W'(120);
   localparam logic [DELAY_W-1:0] UPDATE_DELAY_RESET   = DELAY_W'(20);
   localparam logic [DUTY_W-1:0]  PEAK_INTENSITY_RESET = DUTY_W'(950);

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [MUL_P_W-1:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] step_index;
      logic [STEP_W-1:0] fade_steps;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [PROG_W-1:0] progress;
   } div_rsp_type;

   // sin(pi/2 * z) series coefficients in Q30, highest order first
   function automatic logic [MUL_A_W-1:0] sine_coef(input logic [COEF_IDX_W-1:0] idx);
      logic [MUL_A_W-1:0] c;
      case (idx)
         3'd0:    c = MUL_A_W'(172272);
         3'd1:    c = MUL_A_W'(5026995);
         3'd2:    c = MUL_A_W'(85569306);
         3'd3:    c = MUL_A_W'(693598668);
         3'd4:    c = MUL_A_W'(1686629713);
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

// File: src/rbs_serial_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module rbs_serial_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  rbs_pkg::mul_req_type mul_req,
   output rbs_pkg::mul_rsp_type mul_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [rbs_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [rbs_pkg::MUL_A_W-1:0]   a_ff, a_in;
   logic [rbs_pkg::MUL_A_W-1:0]   hi_ff, hi_in;
   logic [rbs_pkg::MUL_B_W-1:0]   lo_ff, lo_in;
   logic [rbs_pkg::MUL_A_W:0]     sum;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      if (mul_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = mul_req.a;
         hi_in   = '0;
         lo_in   = mul_req.b;
      end else if (busy_ff) begin
         hi_in  = sum[rbs_pkg::MUL_A_W:1];
         lo_in  = {sum[0], lo_ff[rbs_pkg::MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rbs_pkg::MUL_CNT_W'(rbs_pkg::MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign mul_rsp.busy    = busy_ff;
   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = {hi_ff, lo_ff};

endmodule

// File: src/rbs_serial_div.sv
// Restoring divider for breathing progress, one quotient bit per cycle.
module rbs_serial_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rbs_pkg::div_req_type div_req,
   output rbs_pkg::div_rsp_type div_rsp
);

   localparam logic [rbs_pkg::DIV_N-1:0] FULL_P = rbs_pkg::DIV_N'(1) << rbs_pkg::PROGRESS_BITS;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [rbs_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [rbs_pkg::DIV_N-1:0]     num_ff, num_in;
   logic [rbs_pkg::STEP_W-1:0]    rem_ff, rem_in;
   logic [rbs_pkg::STEP_W-1:0]    den_ff, den_in;
   logic [rbs_pkg::STEP_W:0]      trial;
   logic [rbs_pkg::STEP_W:0]      diff;
   logic                          fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, num_ff[rbs_pkg::DIV_N-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = (trial >= {1'b0, den_ff});
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = {div_req.step_index, rbs_pkg::PROGRESS_BITS'(0)};
         rem_in  = '0;
         den_in  = div_req.fade_steps;
      end else if (busy_ff) begin
         rem_in = fits ? diff[rbs_pkg::STEP_W-1:0] : trial[rbs_pkg::STEP_W-1:0];
         num_in = {num_ff[rbs_pkg::DIV_N-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rbs_pkg::DIV_CNT_W'(rbs_pkg::DIV_N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.progress = (num_ff > FULL_P) ? FULL_P[rbs_pkg::PROG_W-1:0]
                                               : num_ff[rbs_pkg::PROG_W-1:0];

endmodule

// File: src/rgb_rainbow_breathing_sequencer_top.sv
// Top level of the RGB rainbow breathing sequencer.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_now_ms
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_red_duty, rsp_green_duty, rsp_blue_duty
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// A transaction that makes no update goes from the check state back to idle; an update uses
// 14 passes of the shared 16-bit serial multiplier and one pass of the serial divider, and
// waits in the output state until the result register is free.
// One transaction is worked at a time; req_stall is high until it is finished.
// The result register frees the input side while rsp is stalled.
// Reset is synchronous and restores the register defaults and the breathing state.
module rgb_rainbow_breathing_sequencer_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rbs_pkg::TIME_W-1:0]         req_now_ms,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rbs_pkg::DUTY_W-1:0]         rsp_red_duty,
   output logic [rbs_pkg::DUTY_W-1:0]         rsp_green_duty,
   output logic [rbs_pkg::DUTY_W-1:0]         rsp_blue_duty,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rbs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rbs_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_DIV    = 4'd2;
   localparam logic [3:0] S_FOLD   = 4'd3;
   localparam logic [3:0] S_SQ     = 4'd4;
   localparam logic [3:0] S_HORNER = 4'd5;
   localparam logic [3:0] S_FIN    = 4'd6;
   localparam logic [3:0] S_TENTH  = 4'd7;
   localparam logic [3:0] S_SCALE  = 4'd8;
   localparam logic [3:0] S_OUT    = 4'd9;

   localparam logic [rbs_pkg::HUE_W-1:0] HUE_ORANGE     = 4'd1;
   localparam logic [rbs_pkg::HUE_W-1:0] HUE_YELLOW     = 4'd2;
   localparam logic [rbs_pkg::HUE_W-1:0] HUE_CHARTREUSE = 4'd3;
   localparam logic [rbs_pkg::HUE_W-1:0] HUE_GREEN      = 4'd4;
   localparam logic [rbs_pkg::HUE_W-1:0] HUE_SPRING     = 4'd5;
   localparam logic [rbs_pkg::HUE_W-1:0] HUE_CYAN       = 4'd6;
   localparam logic [rbs_pkg::HUE_W-1:0] HUE_AZURE      = 4'd7;
   localparam logic [rbs_pkg::HUE_W-1:0] HUE_BLUE       = 4'd8;
   localparam logic [rbs_pkg::HUE_W-1:0] HUE_VIOLET     = 4'd9;
   localparam logic [rbs_pkg::HUE_W-1:0] HUE_MAGENTA    = 4'd10;
   localparam logic [rbs_pkg::HUE_W-1:0] HUE_ROSE       = 4'd11;

   localparam int W_SUM_W = rbs_pkg::MAG_W + 2;
   localparam logic [rbs_pkg::COEF_IDX_W-1:0] COEF_LAST =
      rbs_pkg::COEF_IDX_W'(rbs_pkg::COEF_N - 1);

   logic [3:0]                         state_ff, state_in;
   logic [rbs_pkg::TIME_W-1:0]         now_ff, now_in;
   logic [rbs_pkg::TIME_W-1:0]         last_ff, last_in;
   logic [rbs_pkg::STEP_W-1:0]         fade_steps_ff, fade_steps_in;
   logic [rbs_pkg::DELAY_W-1:0]        delay_ff, delay_in;
   logic [rbs_pkg::DUTY_W-1:0]         peak_ff, peak_in;
   logic [rbs_pkg::STEP_W-1:0]         step_ff, step_in;
   logic                               fading_ff, fading_in;
   logic [rbs_pkg::HUE_W-1:0]          hue_ff, hue_in;
   logic                               sel_ff, sel_in;
   logic [rbs_pkg::COEF_IDX_W-1:0]     term_ff, term_in;
   logic [rbs_pkg::ANGLE_W-1:0]        u1_ff, u1_in;
   logic [rbs_pkg::Q15_W-1:0]          z_ff, z_in;
   logic [rbs_pkg::Q15_W-1:0]          z2_ff, z2_in;
   logic                               neg_ff, neg_in;
   logic [rbs_pkg::MAG_W-1:0]          mag1_ff, mag1_in;
   logic                               neg1_ff, neg1_in;
   logic [rbs_pkg::DUTY_W-1:0]         inten_ff, inten_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [rbs_pkg::DUTY_W-1:0]         red_ff, red_in;
   logic [rbs_pkg::DUTY_W-1:0]         green_ff, green_in;
   logic [rbs_pkg::DUTY_W-1:0]         blue_ff, blue_in;

   rbs_pkg::mul_req_type               mul_req;
   rbs_pkg::mul_rsp_type               mul_rsp;
   rbs_pkg::div_req_type               div_req;
   rbs_pkg::div_rsp_type               div_rsp;

   logic [rbs_pkg::TIME_W-1:0]         elapsed;
   logic [rbs_pkg::ANGLE_W-1:0]        angle;
   logic [rbs_pkg::ANGLE_W-1:0]        folded;
   logic [rbs_pkg::ANGLE_W-1:0]        quarter;
   logic [rbs_pkg::MUL_A_W-1:0]        horner;
   logic [rbs_pkg::TENTH_W-1:0]        tenth;
   logic signed [W_SUM_W-1:0]          s1;
   logic signed [W_SUM_W-1:0]          s2;
   logic signed [W_SUM_W-1:0]          wsum;
   logic [rbs_pkg::Q15_W-1:0]          wave;
   logic [rbs_pkg::DUTY_W-1:0]         half;
   logic [rbs_pkg::DUTY_W-1:0]         r_raw, g_raw, b_raw;
   logic [rbs_pkg::STEP_W-1:0]         step_up, step_down;
   logic                               out_free;

   function automatic logic [rbs_pkg::DUTY_W-1:0] clamp_duty(
      input logic [rbs_pkg::DUTY_W-1:0] x);
      return (x > rbs_pkg::DUTY_LIMIT) ? rbs_pkg::DUTY_LIMIT : x;
   endfunction

   rbs_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   rbs_serial_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      elapsed = now_ff - last_ff;

      angle   = sel_ff ? (u1_ff << 1) : u1_ff;
      folded  = (angle <= rbs_pkg::HALF_TURN) ? angle : angle - rbs_pkg::HALF_TURN;
      quarter = (folded <= rbs_pkg::QUARTER_TURN) ? folded : rbs_pkg::HALF_TURN - folded;

      horner = rbs_pkg::sine_coef(term_ff) - mul_rsp.product[rbs_pkg::MUL_P_W-2:15];
      tenth  = mul_rsp.product[rbs_pkg::TENTH_SHIFT+rbs_pkg::TENTH_W-1:rbs_pkg::TENTH_SHIFT];

      s1 = $signed({2'b00, mag1_ff});
      if (neg1_ff) begin
         s1 = -s1;
      end
      s2 = $signed({(W_SUM_W-rbs_pkg::TENTH_W)'(0), tenth});
      if (neg_ff) begin
         s2 = -s2;
      end
      wsum = s1 + s2;
      if (wsum[W_SUM_W-1]) begin
         wave = '0;
      end else if (wsum > $signed(W_SUM_W'(rbs_pkg::Q15_ONE))) begin
         wave = rbs_pkg::Q15_ONE;
      end else begin
         wave = wsum[rbs_pkg::Q15_W-1:0];
      end

      half = inten_ff >> 1;
      case (hue_ff)
         HUE_ORANGE:     begin r_raw = inten_ff; g_raw = half;     b_raw = '0;       end
         HUE_YELLOW:     begin r_raw = inten_ff; g_raw = inten_ff; b_raw = '0;       end
         HUE_CHARTREUSE: begin r_raw = half;     g_raw = inten_ff; b_raw = '0;       end
         HUE_GREEN:      begin r_raw = '0;       g_raw = inten_ff; b_raw = '0;       end
         HUE_SPRING:     begin r_raw = '0;       g_raw = inten_ff; b_raw = half;     end
         HUE_CYAN:       begin r_raw = '0;       g_raw = inten_ff; b_raw = inten_ff; end
         HUE_AZURE:      begin r_raw = '0;       g_raw = half;     b_raw = inten_ff; end
         HUE_BLUE:       begin r_raw = '0;       g_raw = '0;       b_raw = inten_ff; end
         HUE_VIOLET:     begin r_raw = half;     g_raw = '0;       b_raw = inten_ff; end
         HUE_MAGENTA:    begin r_raw = inten_ff; g_raw = '0;       b_raw = inten_ff; end
         HUE_ROSE:       begin r_raw = inten_ff; g_raw = '0;       b_raw = half;     end
         default:        begin r_raw = inten_ff; g_raw = '0;       b_raw = '0;       end
      endcase

      step_up   = step_ff + 1'b1;
      step_down = step_ff - 1'b1;
   end

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      last_in       = last_ff;
      fade_steps_in = fade_steps_ff;
      delay_in      = delay_ff;
      peak_in       = peak_ff;
      step_in       = step_ff;
      fading_in     = fading_ff;
      hue_in        = hue_ff;
      sel_in        = sel_ff;
      term_in       = term_ff;
      u1_in         = u1_ff;
      z_in          = z_ff;
      z2_in         = z2_ff;
      neg_in        = neg_ff;
      mag1_in       = mag1_ff;
      neg1_in       = neg1_ff;
      inten_in      = inten_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      red_in        = red_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      mul_req       = '0;
      div_req       = '0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rbs_pkg::CSR_FADE_STEPS:     fade_steps_in = csr_data[rbs_pkg::STEP_W-1:0];
            rbs_pkg::CSR_UPDATE_DELAY:   delay_in      = csr_data[rbs_pkg::DELAY_W-1:0];
            rbs_pkg::CSR_PEAK_INTENSITY: peak_in       = csr_data[rbs_pkg::DUTY_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               now_in   = req_now_ms;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (elapsed < rbs_pkg::TIME_W'(delay_ff)) begin
               state_in = S_IDLE;
            end else begin
               last_in            = now_ff;
               div_req.start      = 1'b1;
               div_req.step_index = step_ff;
               div_req.fade_steps = fade_steps_ff;
               state_in           = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               u1_in    = rbs_pkg::ANGLE_W'(div_rsp.progress) << (16 - rbs_pkg::PROGRESS_BITS);
               sel_in   = 1'b0;
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            z_in          = quarter[rbs_pkg::Q15_W-1:0];
            neg_in        = (angle > rbs_pkg::HALF_TURN);
            mul_req.start = 1'b1;
            mul_req.a     = rbs_pkg::MUL_A_W'(quarter);
            mul_req.b     = quarter[rbs_pkg::MUL_B_W-1:0];
            state_in      = S_SQ;
         end
         S_SQ: begin
            if (mul_rsp.done) begin
               z2_in         = mul_rsp.product[rbs_pkg::Q15_W+14:15];
               term_in       = rbs_pkg::COEF_IDX_W'(1);
               mul_req.start = 1'b1;
               mul_req.a     = rbs_pkg::sine_coef('0);
               mul_req.b     = mul_rsp.product[rbs_pkg::Q15_W+14:15];
               state_in      = S_HORNER;
            end
         end
         S_HORNER: begin
            if (mul_rsp.done) begin
               mul_req.start = 1'b1;
               mul_req.a     = horner;
               if (term_ff == COEF_LAST) begin
                  mul_req.b = z_ff;
                  state_in  = S_FIN;
               end else begin
                  mul_req.b = z2_ff;
                  term_in   = term_ff + 1'b1;
               end
            end
         end
         S_FIN: begin
            if (mul_rsp.done) begin
               if (!sel_ff) begin
                  mag1_in  = mul_rsp.product[rbs_pkg::MUL_P_W-1:30];
                  neg1_in  = neg_ff;
                  sel_in   = 1'b1;
                  state_in = S_FOLD;
               end else begin
                  mul_req.start = 1'b1;
                  mul_req.a     = rbs_pkg::MUL_A_W'(mul_rsp.product[rbs_pkg::MUL_P_W-1:30]);
                  mul_req.b     = rbs_pkg::TENTH_RECIP;
                  state_in      = S_TENTH;
               end
            end
         end
         S_TENTH: begin
            if (mul_rsp.done) begin
               mul_req.start = 1'b1;
               mul_req.a     = rbs_pkg::MUL_A_W'(wave);
               mul_req.b     = rbs_pkg::MUL_B_W'(peak_ff);
               state_in      = S_SCALE;
            end
         end
         S_SCALE: begin
            if (mul_rsp.done) begin
               inten_in = mul_rsp.product[rbs_pkg::DUTY_W+14:15];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               red_in       = clamp_duty(r_raw);
               green_in     = clamp_duty(g_raw);
               blue_in      = clamp_duty(b_raw);
               if (!fading_ff) begin
                  step_in = step_up;
                  if (step_up >= fade_steps_ff) begin
                     fading_in = 1'b1;
                  end
               end else begin
                  step_in = step_down;
                  if (step_down == '0) begin
                     fading_in = 1'b0;
                     hue_in    = (hue_ff >= rbs_pkg::PHASE_LAST) ? '0 : hue_ff + 1'b1;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_ff       <= '0;
         fade_steps_ff <= rbs_pkg::FADE_STEPS_RESET;
         delay_ff      <= rbs_pkg::UPDATE_DELAY_RESET;
         peak_ff       <= rbs_pkg::PEAK_INTENSITY_RESET;
         step_ff       <= '0;
         fading_ff     <= 1'b0;
         hue_ff        <= '0;
         sel_ff        <= 1'b0;
         term_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_ff       <= last_in;
         fade_steps_ff <= fade_steps_in;
         delay_ff      <= delay_in;
         peak_ff       <= peak_in;
         step_ff       <= step_in;
         fading_ff     <= fading_in;
         hue_ff        <= hue_in;
         sel_ff        <= sel_in;
         term_ff       <= term_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      now_ff   <= now_in;
      u1_ff    <= u1_in;
      z_ff     <= z_in;
      z2_ff    <= z2_in;
      neg_ff   <= neg_in;
      mag1_ff  <= mag1_in;
      neg1_ff  <= neg1_in;
      inten_ff <= inten_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_duty   = red_ff;
   assign rsp_green_duty = green_ff;
   assign rsp_blue_duty  = blue_ff;

   a_mul_start_idle: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> !mul_rsp.busy)
      else $error("multiplier started while busy");

   a_idle_units_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!mul_rsp.busy && !div_rsp.busy))
      else $error("arithmetic unit busy while idle");

   a_duty_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (red_ff <= rbs_pkg::DUTY_LIMIT && green_ff <= rbs_pkg::DUTY_LIMIT
                        && blue_ff <= rbs_pkg::DUTY_LIMIT))
      else $error("duty above limit");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      hue_ff <= rbs_pkg::PHASE_LAST)
      else $error("hue phase out of range");

endmodule
